// File: design/pmt_pkg.sv
`timescale 1ns / 1ps

package pmt_pkg;

   // Field widths of the channels and registers.
   localparam int COORD_W   = 24;
   localparam int DELTA_W   = 16;
   localparam int SPEED_W   = 16;

   // Fixed-point format of the coordinates and of the internal unit vector.
   localparam int FRAC_BITS = 8;
   localparam int UNIT_BITS = 16;
   localparam int LEN_XBITS = 6;
   localparam int MS_PER_S  = 1000;

   // Squares and the square root of their sum.
   localparam int DIFF_W    = COORD_W;
   localparam int SQ_W      = 2 * DIFF_W;
   localparam int SUM_W     = SQ_W + 1;
   localparam int RAD_W     = SUM_W + 2 * LEN_XBITS;
   localparam int ROOT_W    = (RAD_W + 1) / 2;
   localparam int RAD_PAD_W = 2 * ROOT_W;
   localparam int LEN_W     = ROOT_W;
   localparam int SQREM_W   = LEN_W + 2;
   localparam int SQT_W     = SQREM_W + 2;

   // Unit component division: the numerator is the distance shifted up, and its low R_W bits
   // are zero, so the remainder starts as the distance shifted by RDIV_PRE.
   localparam int R_W       = UNIT_BITS + 1;
   localparam int RDIV_PRE  = UNIT_BITS + LEN_XBITS - R_W;

   // Product of speed, elapsed time and unit component.
   localparam int SDT_W     = SPEED_W + DELTA_W;
   localparam int PROD_W    = SDT_W + UNIT_BITS;
   localparam int ACC_W     = (SQ_W > PROD_W) ? SQ_W : PROD_W;

   // Step division by the combined constant of milliseconds and scaling.
   localparam int STEP_W    = DIFF_W + 1;
   localparam int STEP_DIV  = MS_PER_S * (2 ** (UNIT_BITS - FRAC_BITS));
   localparam int DIV_W     = $clog2(STEP_DIV);
   localparam int DIVT_W    = DIV_W + 1;
   localparam int HEAD_W    = ACC_W - STEP_W;

   // Iteration counts of the serial phases.
   localparam int SQ_STEPS   = DIFF_W;
   localparam int ROOT_STEPS = ROOT_W;
   localparam int RDIV_STEPS = R_W;
   localparam int SDIV_STEPS = STEP_W;
   localparam int MAX_A      = (SQ_STEPS > ROOT_STEPS) ? SQ_STEPS : ROOT_STEPS;
   localparam int MAX_B      = (RDIV_STEPS > SDIV_STEPS) ? RDIV_STEPS : SDIV_STEPS;
   localparam int MAX_ITER   = (MAX_A > MAX_B) ? MAX_A : MAX_B;
   localparam int CNT_W      = $clog2(MAX_ITER);

   // Register file.
   localparam int NUM_REGS   = 5;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int CSR_ADDR_W = REG_IDX_W + 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_TARGET_X = 3'd0,
      REG_TARGET_Y = 3'd1,
      REG_SPEED    = 3'd2,
      REG_START_X  = 3'd3,
      REG_START_Y  = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic        [SPEED_W-1:0] speed;
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
   } cfg_type;

   // Control of one axis lane; at most one field is high in a cycle.
   typedef struct packed {
      logic load;
      logic square;
      logic clear;
      logic rdiv;
      logic sdiv_load;
      logic sdiv;
      logic apply;
   } lane_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
   } root_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_RDIV,
      ST_SDIV_LOAD,
      ST_SDIV,
      ST_APPLY,
      ST_DONE
   } state_type;

endpackage

// File: design/pmt_csr.sv
`timescale 1ns / 1ps

module pmt_csr import pmt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [REG_IDX_W-1:0] index;
   logic                 wr_en;

   assign index  = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Register writes; unused addresses are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_TARGET_X: cfg_in.target_x = pwdata[COORD_W-1:0];
            REG_TARGET_Y: cfg_in.target_y = pwdata[COORD_W-1:0];
            REG_SPEED:    cfg_in.speed    = pwdata[SPEED_W-1:0];
            REG_START_X:  cfg_in.start_x  = pwdata[COORD_W-1:0];
            REG_START_Y:  cfg_in.start_y  = pwdata[COORD_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data, zero extended.
   always_comb begin
      unique case (index)
         REG_TARGET_X: prdata = CSR_DATA_W'(unsigned'(cfg_ff.target_x));
         REG_TARGET_Y: prdata = CSR_DATA_W'(unsigned'(cfg_ff.target_y));
         REG_SPEED:    prdata = CSR_DATA_W'(cfg_ff.speed);
         REG_START_X:  prdata = CSR_DATA_W'(unsigned'(cfg_ff.start_x));
         REG_START_Y:  prdata = CSR_DATA_W'(unsigned'(cfg_ff.start_y));
         default:      prdata = '0;
      endcase
   end

endmodule

// File: design/pmt_root.sv
`timescale 1ns / 1ps

module pmt_root import pmt_pkg::*; (
   input  logic              clock,
   input  root_ctrl_type     ctrl,
   input  logic [SQ_W-1:0]   sq_x,
   input  logic [SQ_W-1:0]   sq_y,
   output logic [LEN_W-1:0]  len
);

   logic [RAD_PAD_W-1:0] rad_ff, rad_in;
   logic [SQREM_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]     root_ff, root_in;
   logic [SUM_W-1:0]     sum;
   logic [SQT_W-1:0]     trial;
   logic [SQT_W-1:0]     part;
   logic                 ge;

   assign len = root_ff;

   // One result bit per cycle: two radicand bits are brought down and the trial
   // value four times the root plus one is subtracted when it fits.
   always_comb begin
      sum     = SUM_W'(sq_x) + SUM_W'(sq_y);
      part    = {rem_ff, rad_ff[RAD_PAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = part >= trial;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctrl.load) begin
         rad_in  = RAD_PAD_W'(sum) << (2 * LEN_XBITS);
         rem_in  = '0;
         root_in = '0;
      end else if (ctrl.step) begin
         rad_in  = rad_ff << 2;
         rem_in  = ge ? SQREM_W'(part - trial) : SQREM_W'(part);
         root_in = {root_ff[LEN_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

// File: design/pmt_lane.sv
`timescale 1ns / 1ps

module pmt_lane import pmt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctrl_type             ctrl,
   input  logic                      restart,
   input  logic signed [COORD_W-1:0] start_pos,
   input  logic signed [COORD_W-1:0] target,
   input  logic        [SDT_W-1:0]   sdt,
   input  logic        [LEN_W-1:0]   len,
   output logic        [ACC_W-1:0]   acc,
   output logic signed [COORD_W-1:0] pos
);

   logic signed [COORD_W-1:0] pos_ff, pos_in;
   logic [DIFF_W-1:0]         ad_ff, ad_in;
   logic                      neg_ff, neg_in;
   logic                      nz_ff, nz_in;
   logic [DIFF_W-1:0]         sqsh_ff, sqsh_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [LEN_W-1:0]          rrem_ff, rrem_in;
   logic [DIV_W-1:0]          srem_ff, srem_in;
   logic                      sat_ff, sat_in;
   logic [STEP_W-1:0]         q_ff, q_in;

   logic signed [COORD_W-1:0] cur_eff;
   logic signed [COORD_W:0]   diff;
   logic signed [COORD_W:0]   mag;
   logic [LEN_W:0]            rpart;
   logic                      rge;
   logic [HEAD_W-1:0]         head;
   logic [DIVT_W-1:0]         spart;
   logic                      sge;
   logic [STEP_W-1:0]         stp;
   logic                      hit;

   assign acc = acc_ff;
   assign pos = pos_ff;

   always_comb begin
      // Distance to the target from the position this transaction starts at.
      cur_eff = restart ? start_pos : pos_ff;
      diff    = {target[COORD_W-1], target} - {cur_eff[COORD_W-1], cur_eff};
      mag     = diff[COORD_W] ? -diff : diff;

      // Restoring division step of the unit component, which also feeds the
      // product with speed and time most significant bit first.
      rpart   = {rrem_ff, 1'b0};
      rge     = rpart >= {1'b0, len};

      // Restoring division step of the product by the step constant.
      head    = acc_ff[ACC_W-1:STEP_W];
      spart   = {srem_ff, acc_ff[STEP_W-1]};
      sge     = spart >= DIVT_W'(STEP_DIV);

      // A zero step is raised to one LSB; a step that reaches the target snaps to it.
      stp     = (q_ff == '0) ? STEP_W'(1) : q_ff;
      hit     = sat_ff || (stp >= STEP_W'(ad_ff));

      pos_in  = pos_ff;
      ad_in   = ad_ff;
      neg_in  = neg_ff;
      nz_in   = nz_ff;
      sqsh_in = sqsh_ff;
      acc_in  = acc_ff;
      rrem_in = rrem_ff;
      srem_in = srem_ff;
      sat_in  = sat_ff;
      q_in    = q_ff;

      if (ctrl.load) begin
         pos_in  = cur_eff;
         ad_in   = mag[DIFF_W-1:0];
         neg_in  = diff[COORD_W];
         nz_in   = diff != '0;
         sqsh_in = mag[DIFF_W-1:0];
         acc_in  = '0;
         rrem_in = LEN_W'(mag[DIFF_W-1:0]) << RDIV_PRE;
      end else if (ctrl.square) begin
         acc_in  = {acc_ff[ACC_W-2:0], 1'b0} + (sqsh_ff[DIFF_W-1] ? ACC_W'(ad_ff) : '0);
         sqsh_in = {sqsh_ff[DIFF_W-2:0], 1'b0};
      end else if (ctrl.clear) begin
         acc_in  = '0;
      end else if (ctrl.rdiv) begin
         rrem_in = rge ? LEN_W'(rpart - {1'b0, len}) : LEN_W'(rpart);
         acc_in  = {acc_ff[ACC_W-2:0], 1'b0} + (rge ? ACC_W'(sdt) : '0);
      end else if (ctrl.sdiv_load) begin
         sat_in  = ACC_W'(head) >= ACC_W'(STEP_DIV);
         srem_in = DIV_W'(head);
         q_in    = '0;
      end else if (ctrl.sdiv) begin
         srem_in = sge ? DIV_W'(spart - DIVT_W'(STEP_DIV)) : DIV_W'(spart);
         q_in    = {q_ff[STEP_W-2:0], sge};
         acc_in  = {acc_ff[ACC_W-2:0], 1'b0};
      end else if (ctrl.apply) begin
         if (nz_ff && (sdt != '0)) begin
            if (hit) begin
               pos_in = target;
            end else if (neg_ff) begin
               pos_in = pos_ff - COORD_W'(stp);
            end else begin
               pos_in = pos_ff + COORD_W'(stp);
            end
         end
      end
   end

   // The position is architectural state; the working registers need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      ad_ff   <= ad_in;
      neg_ff  <= neg_in;
      nz_ff   <= nz_in;
      sqsh_ff <= sqsh_in;
      acc_ff  <= acc_in;
      rrem_ff <= rrem_in;
      srem_ff <= srem_in;
      sat_ff  <= sat_in;
      q_ff    <= q_in;
   end

endmodule

// File: design/point_move_toward_target_top.sv
`timescale 1ns / 1ps

// Moves a point toward a target at constant speed, one tick per input transaction.
// Configuration: APB-style port with target_x, target_y, speed, start_x and start_y at
// byte addresses 0, 4, 8, 12 and 16; pready is always high; write only while idle.
// Input channel (req_): delta_ms in milliseconds and restart, which reloads the point
// from the start registers before the step. Output channel (rsp_): the new position in
// signed Q15.8 and arrived, high when the point sits on the target.
// The serial datapath works one bit per cycle through squaring, square root, unit-component
// division merged with the speed-time product, and step division, plus load, apply and
// hand-over steps. A new transaction is accepted only after the previous tick is handed over.
// req_stall is high while a tick is being worked on. The finished result waits in an
// output register while rsp_stall is high, and the next tick may be accepted and worked
// on meanwhile; it is held back only at its hand-over until the register is free.
// Reset clears the registers, the position and the output valid.

module point_move_toward_target_top import pmt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [DELTA_W-1:0]        req_delta_ms,
   input  logic                      req_restart,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [COORD_W-1:0] rsp_pos_x,
   output logic signed [COORD_W-1:0] rsp_pos_y,
   output logic                      rsp_arrived
);

   cfg_type                   cfg;
   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [DELTA_W-1:0]        dt_sh_ff, dt_sh_in;
   logic [SDT_W-1:0]          sdt_ff, sdt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [COORD_W-1:0] rsp_pos_y_ff, rsp_pos_y_in;
   logic                      rsp_arrived_ff, rsp_arrived_in;
   lane_ctrl_type             lane_ctrl;
   root_ctrl_type             root_ctrl;
   logic                      commit;
   logic [ACC_W-1:0]          acc_x, acc_y;
   logic signed [COORD_W-1:0] pos_x, pos_y;
   logic [LEN_W-1:0]          len;

   pmt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pmt_lane u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .restart   (req_restart),
      .start_pos (cfg.start_x),
      .target    (cfg.target_x),
      .sdt       (sdt_ff),
      .len       (len),
      .acc       (acc_x),
      .pos       (pos_x)
   );

   pmt_lane u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .restart   (req_restart),
      .start_pos (cfg.start_y),
      .target    (cfg.target_y),
      .sdt       (sdt_ff),
      .len       (len),
      .acc       (acc_y),
      .pos       (pos_y)
   );

   pmt_root u_root (
      .clock (clock),
      .ctrl  (root_ctrl),
      .sq_x  (acc_x[SQ_W-1:0]),
      .sq_y  (acc_y[SQ_W-1:0]),
      .len   (len)
   );

   assign req_stall   = state_ff != ST_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = rsp_pos_x_ff;
   assign rsp_pos_y   = rsp_pos_y_ff;
   assign rsp_arrived = rsp_arrived_ff;

   // Sequencer: walks the serial phases and counts the iterations of each.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      lane_ctrl = '0;
      root_ctrl = '0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lane_ctrl.load = 1'b1;
               cnt_in         = CNT_W'(SQ_STEPS - 1);
               state_in       = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            lane_ctrl.square = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ROOT_LOAD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_ROOT_LOAD: begin
            root_ctrl.load  = 1'b1;
            lane_ctrl.clear = 1'b1;
            cnt_in          = CNT_W'(ROOT_STEPS - 1);
            state_in        = ST_ROOT;
         end
         ST_ROOT: begin
            root_ctrl.step = 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CNT_W'(RDIV_STEPS - 1);
               state_in = ST_RDIV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_RDIV: begin
            lane_ctrl.rdiv = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SDIV_LOAD;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SDIV_LOAD: begin
            lane_ctrl.sdiv_load = 1'b1;
            cnt_in              = CNT_W'(SDIV_STEPS - 1);
            state_in            = ST_SDIV;
         end
         ST_SDIV: begin
            lane_ctrl.sdiv = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_APPLY;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_APPLY: begin
            lane_ctrl.apply = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Speed times elapsed time, built serially during the last squaring cycles.
   always_comb begin
      dt_sh_in = dt_sh_ff;
      sdt_in   = sdt_ff;
      if (lane_ctrl.load) begin
         dt_sh_in = req_delta_ms;
         sdt_in   = '0;
      end else if (lane_ctrl.square && (int'(cnt_ff) < DELTA_W)) begin
         dt_sh_in = {dt_sh_ff[DELTA_W-2:0], 1'b0};
         sdt_in   = {sdt_ff[SDT_W-2:0], 1'b0}
                  + (dt_sh_ff[DELTA_W-1] ? SDT_W'(cfg.speed) : '0);
      end
   end

   // Output register: loaded at hand-over, cleared once the transaction is taken.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_pos_x_in   = rsp_pos_x_ff;
      rsp_pos_y_in   = rsp_pos_y_ff;
      rsp_arrived_in = rsp_arrived_ff;
      if (commit) begin
         rsp_valid_in   = 1'b1;
         rsp_pos_x_in   = pos_x;
         rsp_pos_y_in   = pos_y;
         rsp_arrived_in = (pos_x == cfg.target_x) && (pos_y == cfg.target_y);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_sh_ff       <= dt_sh_in;
      sdt_ff         <= sdt_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_arrived_ff <= rsp_arrived_in;
   end

   // A result is only ever presented from the hand-over state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result presented outside hand-over");

   // Every phase has run its full count before a load or apply cycle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT_LOAD || state_ff == ST_SDIV_LOAD || state_ff == ST_APPLY)
      |-> (cnt_ff == '0))
      else $error("serial phase cut short");

   // An accepted transaction starts the squaring phase with a full count.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall)
      |=> (state_ff == ST_SQUARE) && (cnt_ff == CNT_W'(SQ_STEPS - 1)))
      else $error("accepted transaction did not start squaring");

endmodule

// File: sim/point_move_toward_target_top_tb.sv
`timescale 1ns / 1ps

module point_move_toward_target_top_tb;
   import pmt_pkg::*;

   typedef struct {
      logic [DELTA_W-1:0] delta_ms;
      logic               restart;
   } tick_item_type;

   typedef struct {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic                      arrived;
   } position_type;

   logic                      clock;
   logic                      reset        = 1'b1;
   logic                      psel         = 1'b0;
   logic                      penable      = 1'b0;
   logic                      pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0]     paddr        = '0;
   logic [CSR_DATA_W-1:0]     pwdata       = '0;
   logic [CSR_DATA_W-1:0]     prdata;
   logic                      pready;
   logic                      req_valid    = 1'b0;
   logic                      req_stall;
   logic [DELTA_W-1:0]        req_delta_ms = '0;
   logic                      req_restart  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall    = 1'b0;
   logic signed [COORD_W-1:0] rsp_pos_x;
   logic signed [COORD_W-1:0] rsp_pos_y;
   logic                      rsp_arrived;

   // Our own copy of the registers and of the moving point.
   logic signed [COORD_W-1:0] tgt_x = '0;
   logic signed [COORD_W-1:0] tgt_y = '0;
   logic signed [COORD_W-1:0] org_x = '0;
   logic signed [COORD_W-1:0] org_y = '0;
   logic        [SPEED_W-1:0] spd   = '0;
   logic signed [COORD_W-1:0] pt_x  = '0;
   logic signed [COORD_W-1:0] pt_y  = '0;

   tick_item_type tick_queue[$];
   position_type  position_queue[$];

   int ticks_waiting      = 0;
   int gap_left           = 0;
   int stall_left         = 0;
   int sender_gap_max     = 0;
   int receiver_stall_max = 0;
   int mismatches         = 0;
   int results_seen       = 0;
   int arrivals_seen      = 0;
   int reloads_seen       = 0;
   int scenes_set         = 0;

   point_move_toward_target_top uut (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_delta_ms (req_delta_ms),
      .req_restart  (req_restart),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_pos_x    (rsp_pos_x),
      .rsp_pos_y    (rsp_pos_y),
      .rsp_arrived  (rsp_arrived)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // Moves one axis toward its target by the scaled step, never past it.
   function automatic logic signed [COORD_W-1:0] axis_advance(
      input logic signed [COORD_W-1:0] from,
      input logic signed [COORD_W-1:0] to,
      input longint unsigned           len,
      input longint unsigned           sdt
   );
      longint          d;
      longint unsigned ad;
      longint unsigned frac;
      longint unsigned step;
      d = longint'(to) - longint'(from);
      if (d == 0 || sdt == 0) begin
         return from;
      end
      ad   = (d < 0) ? -d : d;
      frac = (ad << (UNIT_BITS + LEN_XBITS)) / len;
      step = ((sdt * frac) << FRAC_BITS) / (longint'(MS_PER_S) << UNIT_BITS);
      // A step that rounds to nothing still moves by one LSB, so the point always lands.
      if (step == 0) begin
         step = 1;
      end
      if (step >= ad) begin
         return to;
      end
      return (d > 0) ? from + COORD_W'(step) : from - COORD_W'(step);
   endfunction

   // Applies one tick to our copy of the point and returns the position it should report.
   function automatic position_type advance_point(
      input logic [DELTA_W-1:0] dt,
      input logic               reload
   );
      position_type              res;
      longint                    dx;
      longint                    dy;
      longint unsigned           ax;
      longint unsigned           ay;
      longint unsigned           rad;
      longint unsigned           root;
      longint unsigned           bitv;
      longint unsigned           sdt;
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
      if (reload) begin
         pt_x = org_x;
         pt_y = org_y;
         reloads_seen++;
      end
      if (pt_x != tgt_x || pt_y != tgt_y) begin
         dx  = longint'(tgt_x) - longint'(pt_x);
         dy  = longint'(tgt_y) - longint'(pt_y);
         ax  = (dx < 0) ? -dx : dx;
         ay  = (dy < 0) ? -dy : dy;
         rad = (ax * ax + ay * ay) << (2 * LEN_XBITS);
         // Integer square root, one result bit per pass.
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > rad) begin
            bitv >>= 2;
         end
         while (bitv != 0) begin
            if (rad >= root + bitv) begin
               rad  -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         sdt  = longint'(spd) * longint'(dt);
         nx   = axis_advance(pt_x, tgt_x, root, sdt);
         ny   = axis_advance(pt_y, tgt_y, root, sdt);
         pt_x = nx;
         pt_y = ny;
      end
      res.pos_x   = pt_x;
      res.pos_y   = pt_y;
      res.arrived = (pt_x == tgt_x && pt_y == tgt_y);
      return res;
   endfunction

   // One register write: a setup phase, then an access phase until pready.
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_TARGET_X: tgt_x = data[COORD_W-1:0];
         REG_TARGET_Y: tgt_y = data[COORD_W-1:0];
         REG_SPEED:    spd   = data[SPEED_W-1:0];
         REG_START_X:  org_x = data[COORD_W-1:0];
         REG_START_Y:  org_y = data[COORD_W-1:0];
         default: ;
      endcase
   endtask

   // Writes every register; the bits above each register's width carry noise.
   task automatic set_scene(
      input logic [COORD_W-1:0] tx,
      input logic [COORD_W-1:0] ty,
      input logic [SPEED_W-1:0] speed_px,
      input logic [COORD_W-1:0] sx,
      input logic [COORD_W-1:0] sy
   );
      csr_write(REG_TARGET_X, {8'($urandom), tx});
      csr_write(REG_TARGET_Y, {8'($urandom), ty});
      csr_write(REG_SPEED, {16'($urandom), speed_px});
      csr_write(REG_START_X, {8'($urandom), sx});
      csr_write(REG_START_Y, {8'($urandom), sy});
      scenes_set++;
   endtask

   task automatic queue_tick(input logic [DELTA_W-1:0] dt, input logic reload);
      tick_item_type item;
      item.delta_ms = dt;
      item.restart  = reload;
      tick_queue.push_back(item);
      ticks_waiting++;
   endtask

   // Holds the sender back until every queued tick has been answered.
   task automatic wait_drained();
      do @(posedge clock); while (ticks_waiting != 0 || position_queue.size() != 0);
   endtask

   function automatic logic [COORD_W-1:0] pick_extreme();
      case ($urandom_range(0, 3))
         0:       return 24'h7FFFFF;
         1:       return 24'h800000;
         2:       return 24'h000000;
         default: return 24'hFFFFFF;
      endcase
   endfunction

   // One random setting of the registers followed by a run of ticks.
   task automatic random_phase(input int n_ticks, input bit quiet);
      logic [COORD_W-1:0] tx;
      logic [COORD_W-1:0] ty;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [SPEED_W-1:0] speed_px;
      logic [DELTA_W-1:0] dt;
      int                 base_x;
      int                 base_y;
      case ($urandom_range(0, 3))
         0: begin
            tx = COORD_W'($urandom);
            ty = COORD_W'($urandom);
            sx = COORD_W'($urandom);
            sy = COORD_W'($urandom);
         end
         1: begin
            // A short trip somewhere in the plane, so that arrival happens often.
            base_x = int'($urandom_range(0, 8000000)) - 4000000;
            base_y = int'($urandom_range(0, 8000000)) - 4000000;
            tx     = COORD_W'(base_x);
            ty     = COORD_W'(base_y);
            sx     = COORD_W'(base_x + int'($urandom_range(0, 16384)) - 8192);
            sy     = COORD_W'(base_y + int'($urandom_range(0, 16384)) - 8192);
         end
         2: begin
            tx = pick_extreme();
            ty = pick_extreme();
            sx = pick_extreme();
            sy = pick_extreme();
         end
         default: begin
            // Motion along one axis only.
            tx = COORD_W'($urandom);
            ty = COORD_W'($urandom);
            if ($urandom_range(0, 1)) begin
               sx = tx;
               sy = COORD_W'($urandom);
            end else begin
               sx = COORD_W'($urandom);
               sy = ty;
            end
         end
      endcase
      case ($urandom_range(0, 7))
         0:       speed_px = '0;
         1:       speed_px = '1;
         2, 3:    speed_px = SPEED_W'($urandom_range(1, 40));
         4, 5:    speed_px = SPEED_W'($urandom_range(40, 2000));
         default: speed_px = SPEED_W'($urandom);
      endcase
      if (quiet) begin
         sender_gap_max     = 0;
         receiver_stall_max = 0;
      end else begin
         sender_gap_max     = ($urandom_range(0, 3) == 0) ? 0 : 18;
         receiver_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
      end
      set_scene(tx, ty, speed_px, sx, sy);
      for (int i = 0; i < n_ticks; i++) begin
         case ($urandom_range(0, 15))
            0:       dt = '0;
            1, 2:    dt = DELTA_W'($urandom);
            default: dt = DELTA_W'($urandom_range(1, 64));
         endcase
         queue_tick(dt, i == 0 || $urandom_range(0, 11) == 0);
      end
      wait_drained();
   endtask

   // Sender: presents queued ticks and predicts each one as its transaction completes.
   always @(posedge clock) begin
      tick_item_type next_tick;
      logic          free;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
      end else begin
         free = !req_valid;
         if (req_valid && !req_stall) begin
            position_queue.push_back(advance_point(req_delta_ms, req_restart));
            ticks_waiting--;
            gap_left = $urandom_range(0, sender_gap_max);
            free     = 1'b1;
         end
         if (free) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (tick_queue.size() != 0) begin
               next_tick = tick_queue.pop_front();
               req_valid    <= 1'b1;
               req_delta_ms <= next_tick.delta_ms;
               req_restart  <= next_tick.restart;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result transaction and holds off the next one at random.
   always @(posedge clock) begin
      position_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_arrived) begin
               arrivals_seen++;
            end
            if (position_queue.size() == 0) begin
               $error("unexpected result: pos_x %0d, pos_y %0d, arrived %0b",
                      rsp_pos_x, rsp_pos_y, rsp_arrived);
               mismatches++;
            end else begin
               want = position_queue.pop_front();
               if (rsp_pos_x !== want.pos_x) begin
                  $error("pos_x: expected %0d, got %0d", want.pos_x, rsp_pos_x);
                  mismatches++;
               end
               if (rsp_pos_y !== want.pos_y) begin
                  $error("pos_y: expected %0d, got %0d", want.pos_y, rsp_pos_y);
                  mismatches++;
               end
               if (rsp_arrived !== want.arrived) begin
                  $error("arrived: expected %0b, got %0b", want.arrived, rsp_arrived);
                  mismatches++;
               end
            end
            stall_left = $urandom_range(0, receiver_stall_max);
         end else if (rsp_valid && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   initial begin
      #25ms;
      $display("[point_move_toward_target_top] ERROR");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset the point already sits on the target at the origin.
      queue_tick(16'd0, 1'b0);
      queue_tick(16'hFFFF, 1'b1);
      wait_drained();

      // Opposite corners of the plane at full speed: a long tick overshoots and clamps.
      set_scene(24'h7FFFFF, 24'h800000, 16'hFFFF, 24'h800000, 24'h7FFFFF);
      queue_tick(16'd1, 1'b1);
      queue_tick(16'd0, 1'b0);
      queue_tick(16'hFFFF, 1'b0);
      queue_tick(16'd5, 1'b0);
      wait_drained();

      // Crawling speed: each step rounds to nothing and is raised to one LSB.
      set_scene(24'd1000, -24'sd300, 16'd1, 24'd0, 24'd0);
      queue_tick(16'd1, 1'b1);
      queue_tick(16'd1, 1'b0);
      queue_tick(16'd2, 1'b0);
      wait_drained();

      // Zero speed leaves the point where the restart put it.
      set_scene(-24'sd5000, 24'd7000, 16'd0, 24'd300, 24'd300);
      queue_tick(16'hFFFF, 1'b1);
      wait_drained();

      // Motion along x only, with no difference on y.
      sender_gap_max     = 18;
      receiver_stall_max = 18;
      set_scene(24'd2560, 24'd0, 16'd50, -24'sd2560, 24'd0);
      queue_tick(16'd20, 1'b1);
      queue_tick(16'd40, 1'b0);
      queue_tick(16'd100, 1'b0);
      wait_drained();

      // A diagonal run that is restarted part of the way along.
      set_scene(-24'sd100, -24'sd100, 16'd300, 24'd100, 24'd100);
      queue_tick(16'd16, 1'b1);
      queue_tick(16'd16, 1'b0);
      queue_tick(16'd16, 1'b0);
      queue_tick(16'd16, 1'b1);
      queue_tick(16'd16, 1'b0);
      wait_drained();

      for (int p = 0; p < 25; p++) begin
         random_phase(70, p % 5 == 0);
      end

      wait_drained();
      repeat (120) @(posedge clock);
      if (position_queue.size() != 0) begin
         $error("%0d expected results never arrived", position_queue.size());
         mismatches++;
      end

      $display("Checked %0d ticks across %0d register settings, with %0d restarts.",
               results_seen, scenes_set, reloads_seen);
      $display("The point reported itself on target in %0d of those ticks.", arrivals_seen);
      if (mismatches == 0) begin
         $display("[point_move_toward_target_top] OK");
      end else begin
         $display("[point_move_toward_target_top] ERROR");
      end
      $finish;
   end

endmodule
